@@ rtl/vertex_transform_4x4_assert.svh @@
// Assertion helpers shared by the transform RTL.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Same-cycle implication.
`define VT4_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define VT4_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/vt4_pkg.sv @@
`timescale 1ns / 1ps
package vt4_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int DIM           = 4;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  acc_t;

    typedef word_t [DIM-1:0] vec_t;
    typedef prod_t [DIM-1:0] prod_vec_t;
    typedef acc_t  [DIM-1:0] acc_vec_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Control that travels with each word down the chain
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [1:0] row_sel;
    } tag_t;

endpackage

@@ rtl/vt4_if.sv @@
`timescale 1ns / 1ps
interface vt4_vertex_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [1:0]           row_sel;
    logic signed [31:0]   in_x;
    logic signed [31:0]   in_y;
    logic signed [31:0]   in_z;
    logic signed [31:0]   in_w;

    modport source (output valid, kind, row_sel, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, kind, row_sel, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vt4_result_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   out_x;
    logic signed [31:0]   out_y;
    logic signed [31:0]   out_z;
    logic signed [31:0]   out_w;
    logic                 overflow;

    modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

@@ rtl/vt4_cell.sv @@
`timescale 1ns / 1ps
`include "vertex_transform_4x4_assert.svh"
module vt4_cell #(
    parameter int ROW       = 0,
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  vt4_pkg::tag_t      tag_in,
    input  vt4_pkg::vec_t      v_in,
    input  vt4_pkg::acc_vec_t  sum_in,
    output vt4_pkg::tag_t      tag_out,
    output vt4_pkg::vec_t      v_out,
    output vt4_pkg::acc_vec_t  sum_out
);
    import vt4_pkg::*;

    localparam logic [1:0] ROW_SEL = 2'(ROW);
    localparam word_t      ONE     = word_t'(64'sd1 <<< FRAC_BITS);
    localparam prod_t      HALF    = (FRAC_BITS == 0) ? prod_t'(0)
                                   : prod_t'(64'sd1 <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0));

    vec_t      row_reg;
    tag_t      tag1_reg;
    vec_t      v1_reg;
    acc_vec_t  sum1_reg;
    prod_vec_t prod_reg;
    prod_vec_t prod_next;
    tag_t      tag2_reg;
    vec_t      v2_reg;
    acc_vec_t  sum2_reg;
    acc_vec_t  sum2_next;
    logic      row_wr;

    assign row_wr = en && tag_in.valid && (tag_in.kind == KIND_LOAD)
                 && (tag_in.row_sel == ROW_SEL);

    // This cell's element of the vector times each entry of its matrix row
    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            prod_next[j] = prod_t'($signed(v_in[ROW])) * prod_t'($signed(row_reg[j]));
        end
    end

    // Round each product and fold it into the running column sum
    always_comb
    begin
        prod_t r;
        r = '0;
        for (int j = 0; j < DIM; j++)
        begin
            r            = (prod_reg[j] + HALF) >>> FRAC_BITS;
            sum2_next[j] = sum1_reg[j] + acc_t'(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                row_reg[j] <= (j == ROW) ? ONE : '0;
            end
        end
        else if (row_wr)
        begin
            row_reg <= v_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= v_in;
            sum1_reg <= sum_in;
            prod_reg <= prod_next;
            v2_reg   <= v1_reg;
            sum2_reg <= sum2_next;
        end
    end

    assign tag_out = tag2_reg;
    assign v_out   = v2_reg;
    assign sum_out = sum2_reg;

    `VT4_ASSERT_NEXT(a_row_only_on_load, !row_wr, $stable(row_reg), "matrix row changed without a load")
    `VT4_ASSERT_NEXT(a_tag_hold_on_stall, !en, $stable(tag2_reg) && $stable(tag1_reg), "tag moved during stall")
    `VT4_ASSERT_NEXT(a_sum_hold_on_stall, !en, $stable(sum2_reg), "partial sum moved during stall")

endmodule

@@ rtl/vt4_sat.sv @@
`timescale 1ns / 1ps
module vt4_sat (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  vt4_pkg::tag_t      tag_in,
    input  vt4_pkg::acc_vec_t  sum_in,
    output logic               valid,
    output vt4_pkg::vec_t      data,
    output logic               overflow
);
    import vt4_pkg::*;

    logic  valid_reg;
    vec_t  data_reg;
    vec_t  data_next;
    logic  ovf_reg;
    logic  ovf_next;

    // Clamp each column sum to the 32-bit range
    always_comb
    begin
        logic [SUM_W-DATA_W:0] hi;
        ovf_next = 1'b0;
        hi       = '0;
        for (int j = 0; j < DIM; j++)
        begin
            hi = sum_in[j][SUM_W-1:DATA_W-1];
            if ((hi == '0) || (hi == '1))
            begin
                data_next[j] = sum_in[j][DATA_W-1:0];
            end
            else
            begin
                data_next[j] = sum_in[j][SUM_W-1] ? WORD_MIN : WORD_MAX;
                ovf_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            // drop load words here: they give no result
            valid_reg <= tag_in.valid && (tag_in.kind == KIND_XFORM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign valid    = valid_reg;
    assign data     = data_reg;
    assign overflow = ovf_reg;

endmodule

@@ rtl/vertex_transform_4x4.sv @@
// Throughput: one word per cycle while no result waits unaccepted; load and transform words mix freely.
// Four row cells of two stages each (multiply, round-accumulate) feed a saturation register;
// while a result waits unaccepted the whole chain holds and vertex.ready is low.
// Reset: the matrix returns to identity and the chain empties.
`timescale 1ns / 1ps
`include "vertex_transform_4x4_assert.svh"
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    vt4_vertex_if.sink          vertex,
    vt4_result_if.source        result
);
    import vt4_pkg::*;

    tag_t     tag_chain [DIM+1];
    vec_t     v_chain   [DIM+1];
    acc_vec_t sum_chain [DIM+1];
    logic     en;
    logic     res_valid;
    vec_t     res_data;
    logic     res_ovf;

    // advance unless a finished result is still waiting
    assign en           = !(res_valid && !result.ready);
    assign vertex.ready = en;

    assign tag_chain[0].valid   = vertex.valid;
    assign tag_chain[0].kind    = vertex.kind;
    assign tag_chain[0].row_sel = vertex.row_sel;
    assign v_chain[0][0]        = vertex.in_x;
    assign v_chain[0][1]        = vertex.in_y;
    assign v_chain[0][2]        = vertex.in_z;
    assign v_chain[0][3]        = vertex.in_w;
    assign sum_chain[0]         = '0;

    for (genvar i = 0; i < DIM; i++)
    begin : g_cell
        vt4_cell #(
            .ROW       (i),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tag_in  (tag_chain[i]),
            .v_in    (v_chain[i]),
            .sum_in  (sum_chain[i]),
            .tag_out (tag_chain[i+1]),
            .v_out   (v_chain[i+1]),
            .sum_out (sum_chain[i+1])
        );
    end

    vt4_sat u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_in   (tag_chain[DIM]),
        .sum_in   (sum_chain[DIM]),
        .valid    (res_valid),
        .data     (res_data),
        .overflow (res_ovf)
    );

    assign result.valid    = res_valid;
    assign result.out_x    = res_data[0];
    assign result.out_y    = res_data[1];
    assign result.out_z    = res_data[2];
    assign result.out_w    = res_data[3];
    assign result.overflow = res_ovf;

    `VT4_ASSERT_NEXT(a_load_gives_nothing, en && tag_chain[DIM].valid && (tag_chain[DIM].kind == KIND_LOAD), !res_valid, "load word produced a result")
    `VT4_ASSERT_NEXT(a_xform_gives_result, en && tag_chain[DIM].valid && (tag_chain[DIM].kind == KIND_XFORM), res_valid, "transform word lost")
    `VT4_ASSERT_SAME(a_ovf_means_clamped, res_valid && res_ovf, (res_data[0] == WORD_MAX) || (res_data[0] == WORD_MIN) || (res_data[1] == WORD_MAX) || (res_data[1] == WORD_MIN) || (res_data[2] == WORD_MAX) || (res_data[2] == WORD_MIN) || (res_data[3] == WORD_MAX) || (res_data[3] == WORD_MIN), "overflow without a clamped element")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
);
    import vt4_pkg::*;

    localparam int TOTAL_WORDS = 1100;
    localparam int CALM_WORDS  = 150;
    localparam int HOLD_AT     = 300;
    localparam int DRAIN_AT    = 600;
    localparam int LONG_HOLD   = 100;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 400000;

    localparam word_t ONE = word_t'(longint'(1) << FRAC_BITS);

    typedef struct packed {
        logic       kind;
        logic [1:0] row_sel;
        word_t      x;
        word_t      y;
        word_t      z;
        word_t      w;
    } vertex_word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        word_t w;
        logic  overflow;
    } result_word_t;

    typedef struct {
        vertex_word_t stim;
        bit           typed;
        result_word_t want;
    } table_row_t;

    logic clk;
    logic rst_n;

    vt4_vertex_if vertex_ch ();
    vt4_result_if result_ch ();

    vertex_transform_4x4 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .result (result_ch)
    );

    word_t        matrix [4][4];
    result_word_t expected_results [$];
    table_row_t   directed_rows [$];
    int           mismatches;
    int           words_sent;
    int           cycles;
    bit           calm;
    bit           long_hold_req;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint round_mul(word_t a, word_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + ((longint'(1) << FRAC_BITS) >>> 1)) >>> FRAC_BITS;
    endfunction

    function automatic result_word_t transform_vertex(vertex_word_t vw);
        word_t        vin [4];
        word_t        vout [4];
        longint       acc;
        result_word_t r;
        vin = '{vw.x, vw.y, vw.z, vw.w};
        r.overflow = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            acc = 0;
            for (int i = 0; i < 4; i++)
                acc += round_mul(vin[i], matrix[i][j]);
            if (acc > longint'(WORD_MAX))
            begin
                vout[j] = WORD_MAX;
                r.overflow = 1'b1;
            end
            else if (acc < longint'(WORD_MIN))
            begin
                vout[j] = WORD_MIN;
                r.overflow = 1'b1;
            end
            else
                vout[j] = word_t'(acc);
        end
        r.x = vout[0];
        r.y = vout[1];
        r.z = vout[2];
        r.w = vout[3];
        return r;
    endfunction

    function automatic void add_row(logic kind, logic [1:0] sel,
                                    word_t x, word_t y, word_t z, word_t w,
                                    bit typed, word_t ex, word_t ey, word_t ez, word_t ew,
                                    logic eo);
        table_row_t row;
        row.stim  = '{kind, sel, x, y, z, w};
        row.typed = typed;
        row.want  = '{ex, ey, ez, ew, eo};
        directed_rows.push_back(row);
    endfunction

    // Mix of small and medium fixed-point values, extremes and raw bit patterns
    function automatic word_t rand_value();
        word_t       v;
        int unsigned pick;
        v    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return v >>> 12;
        if (pick < 60)
            return v >>> 6;
        if (pick < 85)
            return v;
        case ($urandom_range(0, 6))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -1;
            4: return 1;
            5: return ONE;
            default: return -ONE;
        endcase
    endfunction

    function automatic vertex_word_t rand_vertex(logic kind, logic [1:0] sel);
        vertex_word_t vw;
        vw.kind    = kind;
        vw.row_sel = sel;
        vw.x       = rand_value();
        vw.y       = rand_value();
        vw.z       = rand_value();
        vw.w       = rand_value();
        return vw;
    endfunction

    task automatic send_word(vertex_word_t vw, bit typed, result_word_t typed_result);
        if (words_sent == DRAIN_AT && expected_results.size() != 0)
        begin
            // hold off until the pipeline has drained
            vertex_ch.valid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            vertex_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        vertex_ch.valid   <= 1'b1;
        vertex_ch.kind    <= vw.kind;
        vertex_ch.row_sel <= vw.row_sel;
        vertex_ch.in_x    <= vw.x;
        vertex_ch.in_y    <= vw.y;
        vertex_ch.in_z    <= vw.z;
        vertex_ch.in_w    <= vw.w;
        do
            @(posedge clk);
        while (vertex_ch.ready !== 1'b1);
        if (vw.kind == KIND_LOAD)
        begin
            matrix[vw.row_sel][0] = vw.x;
            matrix[vw.row_sel][1] = vw.y;
            matrix[vw.row_sel][2] = vw.z;
            matrix[vw.row_sel][3] = vw.w;
        end
        else if (typed)
            expected_results.push_back(typed_result);
        else
            expected_results.push_back(transform_vertex(vw));
        words_sent++;
        if (words_sent == HOLD_AT)
            long_hold_req = 1'b1;
        calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_x", want.x, result_ch.out_x);
                check_field("out_y", want.y, result_ch.out_y);
                check_field("out_z", want.z, result_ch.out_z);
                check_field("out_w", want.w, result_ch.out_w);
                check_field("overflow", {31'b0, want.overflow}, {31'b0, result_ch.overflow});
            end
        end
    end

    // Result side: short random stalls, one long hold, none at the end
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && !calm && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 6);
            if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        int unsigned first;
        int unsigned burst;
        mismatches    = 0;
        words_sent    = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        rst_n             <= 1'b0;
        vertex_ch.valid   <= 1'b0;
        vertex_ch.kind    <= KIND_LOAD;
        vertex_ch.row_sel <= '0;
        vertex_ch.in_x    <= '0;
        vertex_ch.in_y    <= '0;
        vertex_ch.in_z    <= '0;
        vertex_ch.in_w    <= '0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                matrix[i][j] = (i == j) ? ONE : '0;

        // identity after reset passes vectors through unchanged
        add_row(KIND_XFORM, 2'd3, WORD_MAX, WORD_MIN, 0, -1,
                1'b1, WORD_MAX, WORD_MIN, 0, -1, 1'b0);
        add_row(KIND_XFORM, 2'd0, 1, -1, ONE, -ONE,
                1'b1, 1, -1, ONE, -ONE, 1'b0);
        add_row(KIND_XFORM, 2'd1, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1'b0);
        // single huge products saturate both ways
        add_row(KIND_LOAD, 2'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2'd0, WORD_MIN, 0, 0, 0,
                1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1);
        add_row(KIND_XFORM, 2'd2, WORD_MAX, 0, 0, 0,
                1'b1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1);
        add_row(KIND_XFORM, 2'd1, 0, ONE, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
        // smallest step in row 0 exposes rounding of halves
        add_row(KIND_LOAD, 2'd0, 1, 1, 1, 1, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2'd0, 32'sh8000, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2'd3, -32'sh8000, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2'd2, 32'sh7FFF, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2'd1, -32'sh8001, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
        // all-ones matrix: overflow comes from the sum, not the products
        add_row(KIND_LOAD, 2'd1, ONE, ONE, ONE, ONE, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 2'd2, ONE, ONE, ONE, ONE, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 2'd3, ONE, ONE, ONE, ONE, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 2'd0, ONE, ONE, ONE, ONE, 1'b0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2'd0, WORD_MAX, 1, 0, 0,
                1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1);
        add_row(KIND_XFORM, 2'd3, WORD_MIN, -1, 0, 0,
                1'b1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1);
        add_row(KIND_XFORM, 2'd1, WORD_MAX, WORD_MIN, 0, 0, 1'b1, -1, -1, -1, -1, 1'b0);
        add_row(KIND_XFORM, 2'd2, WORD_MAX, 0, 0, 0,
                1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        add_row(KIND_XFORM, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1);
        add_row(KIND_XFORM, 2'd3, 32'sh12345678, -32'sh0FEDCBA9, ONE, -32'sh7FFFFFFF,
                1'b0, 0, 0, 0, 0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);

        while (words_sent < TOTAL_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                // fresh matrix, rows in rotated order
                first = $urandom_range(0, 3);
                for (int r = 0; r < 4; r++)
                    send_word(rand_vertex(KIND_LOAD, 2'(first + r)), 1'b0, '0);
            end
            else if (pick < 3)
                send_word(rand_vertex(KIND_LOAD, 2'($urandom)), 1'b0, '0);
            else
            begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                    send_word(rand_vertex(KIND_XFORM, 2'($urandom)), 1'b0, '0);
            end
        end
        vertex_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
